### src/ira_pkg.sv
package ira_pkg;

  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned RADIX_BITS = 5;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_LETTER_A = 8'h41;
  localparam logic [7:0] CH_MINUS    = 8'h2D;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_CLEAR = 2'd1,
    CELL_CONV  = 2'd2,
    CELL_SHIFT = 2'd3
  } ira_mode_e;

  typedef struct packed {
    ira_mode_e             mode;
    logic [RADIX_BITS-1:0] radix;
  } ira_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_SKIP = 5'b01000,
    ST_EMIT = 5'b10000
  } ira_state_e;

  function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LETTER_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

### src/integer_to_radix_ascii.sv
// channel   direction  handshake                   payload
// in        input      in_valid_i / in_stall_o     value_i
// out       output     out_valid_o / out_stall_i   character_o, last_o
// cfg       input      APB, pready tied high       radix at address 0
//
// Conversion: the magnitude's bits pass through the row of digit cells, one bit per cell per cycle.
// Then leading zero digits are shifted out, keeping at least one digit, before output starts.
// One character per cycle after that while out_stall_i is low; a '-' goes out first for a
// negative value.
// Reset sets radix to 10 and returns to idle; in_stall_o stays high until the last character.
// An output stall while a character is offered freezes the cell row and the sequencer.
module integer_to_radix_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   character_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ira_pkg::*;

  localparam int unsigned NUM_CELLS = VALUE_BITS;
  localparam int unsigned CONV_LAST = VALUE_BITS + NUM_CELLS - 2;
  localparam int unsigned CNT_BITS  = $clog2(CONV_LAST + 1);
  localparam int unsigned REM_BITS  = $clog2(NUM_CELLS + 1);

  ira_state_e              state_q, state_d;
  logic [RADIX_BITS-1:0]   radix_q;
  logic [RADIX_BITS-1:0]   radix_eff;
  logic [VALUE_BITS-1:0]   mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic [REM_BITS-1:0]     rem_q, rem_d;
  ira_ctrl_t               ctrl;
  logic                    in_acc;
  logic                    out_acc;
  logic                    feed_valid;
  logic                    cfg_wr;

  logic                    cell_valid [NUM_CELLS+1];
  logic                    cell_carry [NUM_CELLS+1];
  logic [DIGIT_BITS-1:0]   cell_digit [NUM_CELLS+1];
  logic [DIGIT_BITS-1:0]   top_digit;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & ~paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {27'd0, radix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_wr) begin
      radix_q <= pwdata[RADIX_BITS-1:0];
    end
  end

  always_comb begin
    if (radix_q < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_q;
    end
  end

  // cell row: index 0 is the least significant digit
  assign cell_valid[0] = feed_valid;
  assign cell_carry[0] = mag_q[VALUE_BITS-1];
  assign cell_digit[0] = '0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ira_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .bit_valid_i (cell_valid[k]),
      .bit_i       (cell_carry[k]),
      .digit_i     (cell_digit[k]),
      .bit_valid_o (cell_valid[k+1]),
      .bit_o       (cell_carry[k+1]),
      .digit_o     (cell_digit[k+1])
    );
  end

  assign top_digit = cell_digit[NUM_CELLS];

  // sequencer
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = (state_q == ST_SIGN) | (state_q == ST_EMIT);
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign character_o = (state_q == ST_SIGN) ? CH_MINUS : digit_char(top_digit);
  assign last_o      = (state_q == ST_EMIT) & (rem_q == REM_BITS'(1));

  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    ctrl.mode  = CELL_HOLD;
    ctrl.radix = radix_eff;
    feed_valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d     = value_i[VALUE_BITS-1];
          mag_d     = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
          cnt_d     = '0;
          ctrl.mode = CELL_CLEAR;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.mode  = CELL_CONV;
        feed_valid = (cnt_q < CNT_BITS'(VALUE_BITS));
        mag_d      = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(CONV_LAST)) begin
          rem_d   = REM_BITS'(NUM_CELLS);
          state_d = neg_q ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (out_acc) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top_digit == '0) && (rem_q > REM_BITS'(1))) begin
          ctrl.mode = CELL_SHIFT;
          rem_d     = rem_q - 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (rem_q == REM_BITS'(1)) begin
            state_d = ST_IDLE;
          end else begin
            ctrl.mode = CELL_SHIFT;
            rem_d     = rem_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

`ifndef SYNTHESIS
  // the top cell never overflows
  a_no_top_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cell_carry[NUM_CELLS])
    else $error("carry out of the top digit cell");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CONV))
    else $error("accepted request did not start conversion");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> (state_q == ST_IDLE))
    else $error("block not idle after last character");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while characters pending");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(character_o) && out_valid_o))
    else $error("stalled character changed");
`endif

endmodule

### src/ira_cell.sv
module ira_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ira_pkg::ira_ctrl_t                ctrl_i,
  input  logic                              bit_valid_i,
  input  logic                              bit_i,
  input  logic [ira_pkg::DIGIT_BITS-1:0]    digit_i,
  output logic                              bit_valid_o,
  output logic                              bit_o,
  output logic [ira_pkg::DIGIT_BITS-1:0]    digit_o
);
  import ira_pkg::*;

  logic [DIGIT_BITS-1:0] digit_q, digit_d;
  logic                  valid_q, valid_d;
  logic                  carry_q, carry_d;
  logic [RADIX_BITS-1:0] sum;
  logic [RADIX_BITS-1:0] red;
  logic                  ge;

  // doubled digit plus incoming bit, reduced once by the radix
  assign sum = {digit_q, bit_i};
  assign ge  = (sum >= ctrl_i.radix);
  assign red = ge ? (sum - ctrl_i.radix) : sum;

  always_comb begin
    digit_d = digit_q;
    valid_d = 1'b0;
    carry_d = 1'b0;
    case (ctrl_i.mode)
      CELL_HOLD: begin
        digit_d = digit_q;
      end
      CELL_CLEAR: begin
        digit_d = '0;
      end
      CELL_CONV: begin
        if (bit_valid_i) begin
          digit_d = red[DIGIT_BITS-1:0];
        end
        valid_d = bit_valid_i;
        carry_d = bit_valid_i & ge;
      end
      CELL_SHIFT: begin
        digit_d = digit_i;
      end
      default: begin
        digit_d = digit_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      carry_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign bit_valid_o = valid_q;
  assign bit_o       = carry_q;
  assign digit_o     = digit_q;

endmodule
